>>> hw/rtl/svg_pkg.sv
// Shared constants, types and arithmetic helpers for the star vertex generator.
package svg_pkg;

  localparam int MAX_POINTS   = 32;
  localparam int CORDIC_STEPS = 16;

  localparam int CENTER_W = 12;
  localparam int RADIUS_W = 10;
  localparam int COUNT_W  = 6;
  localparam int COORD_W  = 14;
  localparam int PHASE_W  = 16;
  localparam int DIVSR_W  = 7;
  localparam int DIV_BITS = 17;
  localparam int CORD_W   = 20;
  localparam int ITER_W   = 5;
  localparam int PROD_W   = RADIUS_W + 1 + CORD_W;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN_INIT = 20'sd39797;

  typedef logic signed [CORD_W-1:0] cord_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic cord_t atan_turn(input logic [ITER_W-1:0] idx);
    cord_t v;
    case (idx)
      5'd0:    v = 20'sd131072;
      5'd1:    v = 20'sd77376;
      5'd2:    v = 20'sd40884;
      5'd3:    v = 20'sd20753;
      5'd4:    v = 20'sd10417;
      5'd5:    v = 20'sd5213;
      5'd6:    v = 20'sd2607;
      5'd7:    v = 20'sd1304;
      5'd8:    v = 20'sd652;
      5'd9:    v = 20'sd326;
      5'd10:   v = 20'sd163;
      5'd11:   v = 20'sd81;
      5'd12:   v = 20'sd41;
      5'd13:   v = 20'sd20;
      5'd14:   v = 20'sd10;
      5'd15:   v = 20'sd5;
      5'd16:   v = 20'sd3;
      5'd17:   v = 20'sd1;
      5'd18:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // center + prod / 2^16, truncated toward zero, kept to the coordinate width
  function automatic logic [COORD_W-1:0] place_coord(input logic [CENTER_W-1:0] center,
                                                      input prod_t prod);
    logic signed [31:0] t;
    logic signed [31:0] b;
    t = $signed({4'b0000, center, 16'h0000}) + $signed({{(32-PROD_W){prod[PROD_W-1]}}, prod});
    b = t + (t[31] ? 32'sh0000ffff : 32'sh00000000);
    return b[16+COORD_W-1:16];
  endfunction

endpackage

>>> hw/rtl/svg_div.sv
// Restoring divider that forms 2^16 / divisor, one quotient bit per cycle.
module svg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [svg_pkg::DIVSR_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [svg_pkg::PHASE_W-1:0] quot_o,
  output logic [svg_pkg::DIVSR_W-1:0] rem_o
);
  import svg_pkg::*;

  logic                busy_q, done_q;
  logic [ITER_W-1:0]   cnt_q;
  logic [DIV_BITS-1:0] num_q, quot_q;
  logic [DIVSR_W-1:0]  rem_q, dvs_q;
  logic [DIVSR_W:0]    trial;
  logic                fits;

  assign trial = {rem_q, num_q[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ITER_W'(DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= DIV_BITS'(1) << PHASE_W;
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      num_q  <= {num_q[DIV_BITS-2:0], 1'b0};
      quot_q <= {quot_q[DIV_BITS-2:0], fits};
      rem_q  <= fits ? DIVSR_W'(trial - {1'b0, dvs_q}) : trial[DIVSR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q[PHASE_W-1:0];
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/svg_cordic.sv
// Iterative CORDIC rotation with one shared add and shift stage and quadrant fold.
module svg_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [svg_pkg::PHASE_W-1:0] phase_i,
  output logic                        done_o,
  output svg_pkg::cord_t              sin_o,
  output svg_pkg::cord_t              cos_o
);
  import svg_pkg::*;

  logic              busy_q, done_q;
  logic [ITER_W-1:0] iter_q;
  logic [1:0]        quad_q;
  cord_t             x_q, y_q, z_q;
  cord_t             dx, dy, ang;

  assign dx  = y_q >>> iter_q;
  assign dy  = x_q >>> iter_q;
  assign ang = atan_turn(iter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN_INIT;
      y_q    <= '0;
      z_q    <= $signed({2'b00, phase_i[PHASE_W-3:0], 4'b0000});
      quad_q <= phase_i[PHASE_W-1:PHASE_W-2];
    end else if (busy_q) begin
      if (!z_q[CORD_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  always_comb begin
    case (quad_q)
      2'd0: begin
        sin_o = y_q;
        cos_o = x_q;
      end
      2'd1: begin
        sin_o = x_q;
        cos_o = -y_q;
      end
      2'd2: begin
        sin_o = -y_q;
        cos_o = -x_q;
      end
      default: begin
        sin_o = -x_q;
        cos_o = y_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

>>> hw/rtl/star_vertex_generator.sv
// Star vertex generator: sequencer, phase stepping, shared multiplier and output register.
// Sequence: a divide of 2^16 by twice the point count, then for each vertex a phase step,
// the CORDIC rotation on the shared rotation stage, and multiply and place.
// Requests: one star of S points (clamped to 3..32) at a time; the next request is taken
// once the last vertex sits in the output register.
// Reset: asynchronous active low, returns the sequencer to idle with no vertex pending.
module star_vertex_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_stall_o,
  input  logic [svg_pkg::CENTER_W-1:0] center_x_i,
  input  logic [svg_pkg::CENTER_W-1:0] center_y_i,
  input  logic [svg_pkg::RADIUS_W-1:0] outer_radius_i,
  input  logic [svg_pkg::RADIUS_W-1:0] inner_radius_i,
  input  logic [svg_pkg::COUNT_W-1:0]  point_count_i,
  output logic                         vertex_valid_o,
  input  logic                         vertex_stall_i,
  output logic [svg_pkg::COORD_W-1:0]  vertex_x_o,
  output logic [svg_pkg::COORD_W-1:0]  vertex_y_o,
  output logic                         is_inner_o,
  output logic                         last_o
);
  import svg_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ADV  = 3'd2;
  localparam logic [2:0] ST_ROT  = 3'd3;
  localparam logic [2:0] ST_MULS = 3'd4;
  localparam logic [2:0] ST_MULC = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]          state_q, state_d;
  logic                accept, out_free, emit, is_last;
  logic [CENTER_W-1:0] cx_q, cy_q;
  logic [RADIUS_W-1:0] ro_q, ri_q, r_sel;
  logic [COUNT_W-1:0]  s_clamp;
  logic [DIVSR_W-1:0]  d_q, d_in;
  logic [DIVSR_W-1:0]  vidx_q;
  logic [PHASE_W-1:0]  step_q, phase_q, phase_d;
  logic [DIVSR_W-1:0]  sr_q, rem_q, rem_d;
  logic [DIVSR_W:0]    rem_sum;
  logic                div_done, cor_done;
  logic [PHASE_W-1:0]  div_quot;
  logic [DIVSR_W-1:0]  div_rem;
  cord_t               sin_v, cos_v;
  prod_t               prod_q;
  logic [COORD_W-1:0]  vx_q;
  logic                out_valid_q;

  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !vertex_stall_i;
  assign emit     = (state_q == ST_EMIT) && out_free;
  assign is_last  = vidx_q == DIVSR_W'(d_q - 1'b1);
  assign r_sel    = vidx_q[0] ? ri_q : ro_q;

  always_comb begin
    s_clamp = point_count_i;
    if (point_count_i < COUNT_W'(3)) s_clamp = COUNT_W'(3);
    if (point_count_i > COUNT_W'(MAX_POINTS)) s_clamp = COUNT_W'(MAX_POINTS);
    d_in = {s_clamp, 1'b0};
  end

  // advance the phase by 2^16 / d, carrying the remainder
  always_comb begin
    rem_sum = {1'b0, rem_q} + {1'b0, sr_q};
    if (rem_sum >= {1'b0, d_q}) begin
      rem_d   = DIVSR_W'(rem_sum - {1'b0, d_q});
      phase_d = phase_q + step_q + 1'b1;
    end else begin
      rem_d   = rem_sum[DIVSR_W-1:0];
      phase_d = phase_q + step_q;
    end
  end

  svg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .divisor_i (d_in),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  svg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_ADV),
    .phase_i (phase_d),
    .done_o  (cor_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_ADV;
      ST_ADV:  state_d = ST_ROT;
      ST_ROT:  if (cor_done) state_d = ST_MULS;
      ST_MULS: state_d = ST_MULC;
      ST_MULC: state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = is_last ? ST_IDLE : ST_ADV;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vidx_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_free) out_valid_q <= emit;
      if (state_q == ST_DIV) vidx_q <= '0;
      else if (emit) vidx_q <= vidx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      ro_q <= outer_radius_i;
      ri_q <= inner_radius_i;
      d_q  <= d_in;
    end
    if (state_q == ST_DIV && div_done) begin
      step_q  <= div_quot;
      sr_q    <= div_rem;
      phase_q <= div_quot;
      rem_q   <= div_rem;
    end else if (state_q == ST_ADV) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
    if (state_q == ST_MULS) prod_q <= $signed({1'b0, r_sel}) * sin_v;
    if (state_q == ST_MULC) begin
      vx_q   <= place_coord(cx_q, prod_q);
      prod_q <= $signed({1'b0, r_sel}) * cos_v;
    end
    if (emit) begin
      vertex_x_o <= vx_q;
      vertex_y_o <= place_coord(cy_q, prod_q);
      is_inner_o <= vidx_q[0];
      last_o     <= is_last;
    end
  end

  assign req_stall_o    = state_q != ST_IDLE;
  assign vertex_valid_o = out_valid_q;

endmodule

>>> bench/star_vertex_generator_test.sv
// Self-checking testbench for the star vertex generator: directed and random stars.
module star_vertex_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import svg_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_STARS   = 254;
  localparam int QUIET_STARS    = 25;
  localparam int SETTLE_CYCLES  = 100;
  localparam int CYCLE_LIMIT    = 2_500_000;
  localparam int DIRECTED_COUNT = 16;

  localparam int ATAN_TURNS [0:23] = '{
    131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
    652, 326, 163, 81, 41, 20, 10, 5,
    3, 1, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [RADIUS_W-1:0] ro;
    logic [RADIUS_W-1:0] ri;
    logic [COUNT_W-1:0]  count;
  } star_req_t;

  typedef struct packed {
    star_req_t req;
    logic      at_center;
  } stim_row_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               inner;
    logic               last;
  } vertex_t;

  // at_center rows have both radii zero, so every vertex sits on the center
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{12'd0,    12'd0,    10'd0,    10'd0,    6'd0},  1'b1},
    '{'{12'd4095, 12'd4095, 10'd0,    10'd0,    6'd63}, 1'b1},
    '{'{12'd0,    12'd0,    10'd1023, 10'd1023, 6'd3},  1'b0},
    '{'{12'd4095, 12'd4095, 10'd1023, 10'd1023, 6'd32}, 1'b0},
    '{'{12'd2048, 12'd2048, 10'd1023, 10'd0,    6'd1},  1'b0},
    '{'{12'd2048, 12'd2048, 10'd0,    10'd1023, 6'd2},  1'b0},
    '{'{12'd2048, 12'd2048, 10'd500,  10'd200,  6'd4},  1'b0},
    '{'{12'd1000, 12'd3000, 10'd300,  10'd150,  6'd5},  1'b0},
    '{'{12'hAAA,  12'h555,  10'h2AA,  10'h155,  6'h2A}, 1'b0},
    '{'{12'h555,  12'hAAA,  10'h155,  10'h2AA,  6'h15}, 1'b0},
    '{'{12'd0,    12'd4095, 10'd1,    10'd1,    6'd6},  1'b0},
    '{'{12'd4095, 12'd0,    10'd1023, 10'd1,    6'd33}, 1'b0},
    '{'{12'd100,  12'd100,  10'd1,    10'd0,    6'd31}, 1'b0},
    '{'{12'd0,    12'd0,    10'd2,    10'd1023, 6'd8},  1'b0},
    '{'{12'd3000, 12'd10,   10'd777,  10'd555,  6'd7},  1'b0},
    '{'{12'd12,   12'd4000, 10'd64,   10'd32,   6'd16}, 1'b0}
  };

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                req_valid_i    = 1'b0;
  logic                req_stall_o;
  logic [CENTER_W-1:0] center_x_i     = '0;
  logic [CENTER_W-1:0] center_y_i     = '0;
  logic [RADIUS_W-1:0] outer_radius_i = '0;
  logic [RADIUS_W-1:0] inner_radius_i = '0;
  logic [COUNT_W-1:0]  point_count_i  = '0;
  logic                vertex_valid_o;
  logic                vertex_stall_i = 1'b0;
  logic [COORD_W-1:0]  vertex_x_o;
  logic [COORD_W-1:0]  vertex_y_o;
  logic                is_inner_o;
  logic                last_o;

  vertex_t pending_vertices [$];
  bit      drain_phase      = 1'b0;
  int      mismatches       = 0;
  int      stars_sent       = 0;
  int      full_stars       = 0;
  int      clamped_stars    = 0;
  int      vertices_checked = 0;
  int      cycle_count      = 0;

  star_vertex_generator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .outer_radius_i (outer_radius_i),
    .inner_radius_i (inner_radius_i),
    .point_count_i  (point_count_i),
    .vertex_valid_o (vertex_valid_o),
    .vertex_stall_i (vertex_stall_i),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .is_inner_o     (is_inner_o),
    .last_o         (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int clamped_points(input logic [COUNT_W-1:0] count);
    if (count < 3) return 3;
    if (count > MAX_POINTS) return MAX_POINTS;
    return int'(count);
  endfunction

  function automatic void turn_sin_cos(input logic [PHASE_W-1:0] phase,
                                       output int sin_v, output int cos_v);
    int x;
    int y;
    int z;
    int dx;
    int dy;
    x = int'(CORDIC_GAIN_INIT);
    y = 0;
    z = int'({phase[13:0], 4'b0000});
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TURNS[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TURNS[i];
      end
    end
    case (phase[15:14])
      2'd0: begin sin_v = y;  cos_v = x;  end
      2'd1: begin sin_v = x;  cos_v = -y; end
      2'd2: begin sin_v = -y; cos_v = -x; end
      default: begin sin_v = -x; cos_v = y; end
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] offset_coord(input logic [CENTER_W-1:0] center,
                                                      input logic [RADIUS_W-1:0] radius,
                                                      input int trig);
    longint t;
    longint v;
    t = longint'(center) * 65536 + longint'(radius) * longint'(trig);
    v = (t < 0) ? -((-t) >>> 16) : (t >>> 16);
    return v[COORD_W-1:0];
  endfunction

  function automatic void predict_star(input star_req_t req);
    int            points;
    int            k;
    int            sin_v;
    int            cos_v;
    logic [PHASE_W-1:0]  phase;
    logic [RADIUS_W-1:0] radius;
    vertex_t       v;
    points = clamped_points(req.count);
    for (int i = 1; i <= points; i++) begin
      for (int half = 0; half < 2; half++) begin
        k = 2 * i + half;
        phase = PHASE_W'((k << 16) / (2 * points));
        radius = half ? req.ri : req.ro;
        turn_sin_cos(phase, sin_v, cos_v);
        v.x = offset_coord(req.cx, radius, sin_v);
        v.y = offset_coord(req.cy, radius, cos_v);
        v.inner = (half == 1);
        v.last = (i == points) && (half == 1);
        pending_vertices.push_back(v);
      end
    end
  endfunction

  task automatic offer_star(input star_req_t req, input logic at_center);
    int      points;
    vertex_t v;
    req_valid_i    <= 1'b1;
    center_x_i     <= req.cx;
    center_y_i     <= req.cy;
    outer_radius_i <= req.ro;
    inner_radius_i <= req.ri;
    point_count_i  <= req.count;
    do @(posedge clk_i); while (req_stall_o);
    points = clamped_points(req.count);
    stars_sent++;
    if (points == MAX_POINTS) full_stars++;
    if (points != int'(req.count)) clamped_stars++;
    if (at_center) begin
      for (int k = 0; k < 2 * points; k++) begin
        v.x = {2'b00, req.cx};
        v.y = {2'b00, req.cy};
        v.inner = k[0];
        v.last = (k == 2 * points - 1);
        pending_vertices.push_back(v);
      end
    end else begin
      predict_star(req);
    end
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 2) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("star_vertex_generator test failed");
    $finish;
  end

  initial begin : output_stall
    wait (rst_ni);
    @(posedge clk_i);
    while (!drain_phase) begin
      vertex_stall_i <= ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    vertex_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin : vertex_check
    vertex_t want;
    if (rst_ni && vertex_valid_o && !vertex_stall_i) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d is_inner=%0b last=%0b",
               $signed(vertex_x_o), $signed(vertex_y_o), is_inner_o, last_o);
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        vertices_checked++;
        if (vertex_x_o !== want.x) begin
          $error("vertex_x: expected %0d, got %0d", $signed(want.x), $signed(vertex_x_o));
          mismatches++;
        end
        if (vertex_y_o !== want.y) begin
          $error("vertex_y: expected %0d, got %0d", $signed(want.y), $signed(vertex_y_o));
          mismatches++;
        end
        if (is_inner_o !== want.inner) begin
          $error("is_inner: expected %0b, got %0b", want.inner, is_inner_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    star_req_t req;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      maybe_idle();
      offer_star(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].at_center);
    end

    for (int n = 0; n < RANDOM_STARS; n++) begin
      if (n >= RANDOM_STARS - QUIET_STARS) drain_phase = 1'b1;
      case ($urandom_range(0, 5))
        0: begin
          req.cx = $urandom_range(0, 1) ? '1 : '0;
          req.cy = $urandom_range(0, 1) ? '1 : '0;
        end
        default: begin
          req.cx = CENTER_W'($urandom_range(0, 4095));
          req.cy = CENTER_W'($urandom_range(0, 4095));
        end
      endcase
      req.ro = ($urandom_range(0, 5) == 0) ? RADIUS_W'($urandom_range(0, 3))
                                           : RADIUS_W'($urandom_range(0, 1023));
      req.ri = ($urandom_range(0, 5) == 0) ? RADIUS_W'($urandom_range(0, 3))
                                           : RADIUS_W'($urandom_range(0, 1023));
      // keep most stars small so the run stays short
      req.count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 63))
                                              : COUNT_W'($urandom_range(0, 8));
      if (!drain_phase) maybe_idle();
      offer_star(req, 1'b0);
    end
    req_valid_i <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d stars (%0d with clamped count, %0d at full size), checked %0d vertices.",
             stars_sent, clamped_stars, full_stars, vertices_checked);
    $display("Mismatches: %0d, cycles used: %0d", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("star_vertex_generator test passed");
    end else begin
      $display("star_vertex_generator test failed");
    end
    $finish;
  end

endmodule
